FILE: design/gbci_pkg.sv
// shared types and constants for the gyro bias calibration and integration block
// no dependencies
package gbci_pkg;

  localparam int DECIMATION = 8;
  localparam int CAL_COUNT  = 16;
  localparam int DEC_DIV    = (DECIMATION < 1) ? 1 : DECIMATION;
  localparam int CAL_DIV    = (CAL_COUNT < 1) ? 1 : CAL_COUNT;

  localparam int CNT_W      = 7;
  localparam int GAIN_W     = 10;
  localparam int RAW_W      = 16;
  localparam int TIME_W     = 31;
  localparam int ANG_W      = 32;

  // divide by one million: shift by six, then four 16-bit digits by 15625,
  // each digit as an estimate step, then a remainder update step
  localparam int DIV_SHIFT  = 6;
  localparam int DIGIT_W    = 16;
  localparam int DIV_STEPS  = 8;
  localparam int DIV_CNT_W  = 3;
  localparam int REM_W      = 14;
  localparam int PART_W     = REM_W + DIGIT_W;
  localparam int RECIP_W    = 31;
  localparam int EST_W      = PART_W + RECIP_W;
  localparam int RECIP_SH   = 44;
  localparam int QUO_W      = 44;
  localparam int ACC_W      = 46;

  localparam logic [GAIN_W-1:0]  GAIN_RESET = GAIN_W'(70);
  localparam logic [REM_W-1:0]   DIV_ODD    = REM_W'(15625);
  // ceil(2^44 / 15625), exact for every 30-bit partial dividend
  localparam logic [RECIP_W-1:0] RECIP      = RECIP_W'(1125899907);
  localparam logic signed [ACC_W-1:0] HALF_TURN = ACC_W'(180000);
  localparam logic signed [ACC_W-1:0] FULL_TURN = ACC_W'(360000);

  typedef enum logic [1:0] {
    PH_DISCARD,
    PH_CAL,
    PH_RUN
  } phase_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RATE,
    S_CHECK,
    S_BIAS,
    S_MUL,
    S_DINIT,
    S_DIV,
    S_ACC,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic       load;
    logic       rate;
    logic       bias;
    logic       mul;
    logic       dinit;
    logic       dquo;
    logic       dstep;
    logic       acc;
    logic       emit;
    logic [1:0] axis;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } status_t;

endpackage

FILE: design/gbci_ctrl.sv
// controller for the gyro integrator: phase, sample count and sequencing
// depends on gbci_pkg
module gbci_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  gbci_pkg::status_t status,
  output gbci_pkg::cmd_t    cmd
);
  import gbci_pkg::*;

  state_t               state_r, state_nxt;
  phase_t               phase_r, phase_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [1:0]           axis_r, axis_nxt;
  logic [DIV_CNT_W-1:0] iter_r, iter_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= PH_DISCARD;
      cnt_r   <= '0;
      axis_r  <= '0;
      iter_r  <= '0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      axis_r  <= axis_nxt;
      iter_r  <= iter_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    axis_nxt  = axis_r;
    iter_nxt  = iter_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.axis  = axis_r;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (phase_r == PH_DISCARD) begin
            phase_nxt = PH_CAL;
            cnt_nxt   = '0;
          end else begin
            axis_nxt  = '0;
            state_nxt = S_RATE;
          end
        end
      end
      S_RATE: begin
        cmd.rate = 1'b1;
        if (axis_r == 2'd2) begin
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = S_CHECK;
        end else begin
          axis_nxt = axis_r + 1'b1;
        end
      end
      S_CHECK: begin
        axis_nxt = '0;
        if (phase_r == PH_CAL) begin
          state_nxt = (cnt_r >= CNT_W'(CAL_DIV)) ? S_BIAS : S_IDLE;
        end else begin
          state_nxt = (cnt_r >= CNT_W'(DEC_DIV)) ? S_MUL : S_IDLE;
        end
      end
      S_BIAS: begin
        cmd.bias  = 1'b1;
        cnt_nxt   = '0;
        phase_nxt = PH_RUN;
        state_nxt = S_IDLE;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_DINIT;
      end
      S_DINIT: begin
        cmd.dinit = 1'b1;
        iter_nxt  = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        // even step: digit estimate, odd step: remainder and shift
        if (iter_r[0]) cmd.dstep = 1'b1;
        else cmd.dquo = 1'b1;
        iter_nxt = iter_r + 1'b1;
        if (iter_r == DIV_CNT_W'(DIV_STEPS - 1)) state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.acc = 1'b1;
        if (axis_r == 2'd2) begin
          state_nxt = S_EMIT;
        end else begin
          axis_nxt  = axis_r + 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_EMIT: begin
        if (!status.out_busy) begin
          cmd.emit  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

FILE: design/gbci_dp.sv
// datapath for the gyro integrator: rates, sums, bias, product, digit divider, angles
// depends on gbci_pkg
module gbci_dp (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [gbci_pkg::GAIN_W-1:0] cfg_wdata,
  input  logic signed [gbci_pkg::RAW_W-1:0] in_raw_x,
  input  logic signed [gbci_pkg::RAW_W-1:0] in_raw_y,
  input  logic signed [gbci_pkg::RAW_W-1:0] in_raw_z,
  input  logic [gbci_pkg::TIME_W-1:0] in_time_us,
  input  gbci_pkg::cmd_t            cmd,
  output gbci_pkg::status_t         status,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [gbci_pkg::ANG_W-1:0] out_angle_x,
  output logic signed [gbci_pkg::ANG_W-1:0] out_angle_y,
  output logic signed [gbci_pkg::ANG_W-1:0] out_angle_z
);
  import gbci_pkg::*;

  logic [GAIN_W-1:0]       gain_r;
  logic signed [RAW_W-1:0] raw_r [3];
  logic [TIME_W-1:0]       now_r, last_r;
  logic [31:0]             sum_r [3];
  logic [31:0]             bias_r [3];
  logic [ANG_W-1:0]        ang_r [3];
  logic signed [63:0]      prod_r;
  logic [63:0]             dvd_r;
  logic [63:0]             quo_r;
  logic [REM_W-1:0]        rem_r;
  logic [DIGIT_W-1:0]      qd_r;
  logic                    neg_r;
  logic                    out_valid_r;
  logic [ANG_W-1:0]        out_r [3];

  logic signed [RAW_W+GAIN_W:0] rate_prod;
  logic signed [31:0]           avg, dt;
  logic [63:0]                  mag;
  logic [PART_W-1:0]            part;
  logic [EST_W-1:0]             est;
  logic [PART_W-1:0]            qd_mul;
  logic signed [ACC_W-1:0]      delta, ang_sum, ang_wrap;
  logic [1:0]                   ax;

  assign ax        = cmd.axis;
  assign rate_prod = $signed({1'b0, gain_r}) * raw_r[ax];
  assign avg       = $signed(sum_r[ax]) / DEC_DIV;
  assign dt        = $signed({1'b0, now_r}) - $signed({1'b0, last_r});
  assign mag       = prod_r[63] ? 64'(-prod_r) : 64'(prod_r);
  // current partial dividend: remainder so far and the next digit
  assign part      = {rem_r, dvd_r[63 -: DIGIT_W]};
  assign est       = EST_W'(part) * EST_W'(RECIP);
  assign qd_mul    = PART_W'(qd_r) * PART_W'(DIV_ODD);
  assign delta     = neg_r ? -$signed({2'b00, quo_r[QUO_W-1:0]})
                           :  $signed({2'b00, quo_r[QUO_W-1:0]});
  assign ang_sum   = ACC_W'($signed(ang_r[ax])) + delta;

  always_comb begin
    if (ang_sum > HALF_TURN) ang_wrap = ang_sum - FULL_TURN;
    else if (ang_sum < -HALF_TURN) ang_wrap = ang_sum + FULL_TURN;
    else ang_wrap = ang_sum;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r      <= GAIN_RESET;
      out_valid_r <= 1'b0;
      last_r      <= '0;
      for (int i = 0; i < 3; i++) begin
        sum_r[i]  <= '0;
        bias_r[i] <= '0;
        ang_r[i]  <= '0;
      end
    end else begin
      if (cfg_we) gain_r <= cfg_wdata;
      if (cmd.emit) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      if (cmd.rate) sum_r[ax] <= sum_r[ax] + 32'(rate_prod) - bias_r[ax];
      if (cmd.bias) begin
        for (int i = 0; i < 3; i++) begin
          bias_r[i] <= 32'($signed(sum_r[i]) / CAL_DIV);
          sum_r[i]  <= '0;
        end
        last_r <= now_r;
      end
      if (cmd.acc) begin
        ang_r[ax] <= ang_wrap[ANG_W-1:0];
        sum_r[ax] <= '0;
      end
      if (cmd.emit) last_r <= now_r;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      raw_r[0] <= in_raw_x;
      raw_r[1] <= in_raw_y;
      raw_r[2] <= in_raw_z;
      now_r    <= in_time_us;
    end
    if (cmd.mul) prod_r <= avg * dt;
    if (cmd.dinit) begin
      dvd_r <= mag >> DIV_SHIFT;
      quo_r <= '0;
      rem_r <= '0;
      neg_r <= prod_r[63];
    end else if (cmd.dquo) begin
      qd_r <= est[RECIP_SH +: DIGIT_W];
    end else if (cmd.dstep) begin
      rem_r <= REM_W'(part - qd_mul);
      quo_r <= {quo_r[63-DIGIT_W:0], qd_r};
      dvd_r <= {dvd_r[63-DIGIT_W:0], {DIGIT_W{1'b0}}};
    end
    if (cmd.emit) begin
      for (int i = 0; i < 3; i++) out_r[i] <= ang_r[i];
    end
  end

  assign status.out_busy = out_valid_r && !out_ready;
  assign out_valid   = out_valid_r;
  assign out_angle_x = out_r[0];
  assign out_angle_y = out_r[1];
  assign out_angle_z = out_r[2];

endmodule

FILE: design/gyro_bias_calibrate_integrate.sv
// top level of the gyro bias calibration and rate integration block
// depends on gbci_pkg, gbci_ctrl and gbci_dp

// Takes signed three-axis gyro words with a microsecond timestamp. The first
// word after reset is dropped, the next 16 are averaged into per-axis biases,
// then every group of 8 words is averaged, scaled by elapsed time and added to
// the angles (millidegrees, wrapped once into about +-180000); one angle word
// leaves per group. A word that does not close a group passes the rate step
// once per axis (one shared 11x16 multiplier); the word that ends calibration
// adds a bias step. A group-closing word adds, per axis, a 32x32 product of
// average and elapsed time, then the divide by one million as a shift by six
// and four 16-bit quotient digits by reciprocal multiplication, an estimate and
// a remainder update per digit; a last step loads the output register.
// The finished angles sit in an output register so input words keep flowing
// while the result waits to be taken; if the previous angle word is still
// waiting when the next group closes, input is held off until it is taken.
module gyro_bias_calibrate_integrate (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [gbci_pkg::GAIN_W-1:0]         cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [gbci_pkg::RAW_W-1:0]   in_raw_x,
  input  logic signed [gbci_pkg::RAW_W-1:0]   in_raw_y,
  input  logic signed [gbci_pkg::RAW_W-1:0]   in_raw_z,
  input  logic [gbci_pkg::TIME_W-1:0]         in_time_us,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [gbci_pkg::ANG_W-1:0]   out_angle_x,
  output logic signed [gbci_pkg::ANG_W-1:0]   out_angle_y,
  output logic signed [gbci_pkg::ANG_W-1:0]   out_angle_z
);
  import gbci_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequencer: phase, counts, divider steps
  gbci_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // arithmetic and state
  gbci_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_raw_x    (in_raw_x),
    .in_raw_y    (in_raw_y),
    .in_raw_z    (in_raw_z),
    .in_time_us  (in_time_us),
    .cmd         (cmd),
    .status      (status),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_angle_x (out_angle_x),
    .out_angle_y (out_angle_y),
    .out_angle_z (out_angle_z)
  );

endmodule
